// ----- hdl/gpu_instruction_stream_decoder_unit_defines.svh -----
// assertion macros for the instruction stream decoder
`ifndef GPU_INSTRUCTION_STREAM_DECODER_UNIT_DEFINES_SVH
`define GPU_INSTRUCTION_STREAM_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GISD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GISD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GISD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GISD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/gisd_pkg.sv -----
package gisd_pkg;

  typedef enum logic [4:0] {
    F_UNK = 5'd0, F_VOP2 = 5'd1, F_VOP1 = 5'd2, F_VOPC = 5'd3, F_SOP2 = 5'd4,
    F_SOP1 = 5'd5, F_SOPC = 5'd6, F_SOPP = 5'd7, F_SOPK = 5'd8, F_VINTRP = 5'd9,
    F_VOP3P = 5'd10, F_VOP3 = 5'd11, F_DS = 5'd12, F_FLAT = 5'd13,
    F_MUBUF = 5'd14, F_MTBUF = 5'd15, F_MIMG = 5'd16, F_SMEM = 5'd17, F_EXP = 5'd18
  } enc_class_t;

  typedef enum logic [2:0] {
    X_NONE = 3'd0, X_LIT = 3'd1, X_DPP = 3'd2, X_DPP8 = 3'd3, X_DPP8FI = 3'd4,
    X_SDWA = 3'd5
  } ext_t;

  localparam int MaxWindowDwords = 65536;
  localparam int PcW = 16;
  localparam logic [PcW-1:0] LastOffset = PcW'(MaxWindowDwords - 1);
  localparam logic [8:0] LitCode = 9'd255;
  localparam logic [6:0] SoppCodeEnd = 7'h1F;
  localparam logic [6:0] SoppEndPgm = 7'h01;
  localparam logic [6:0] SoppEndA = 7'h1B;
  localparam logic [6:0] SoppEndB = 7'h1E;
  localparam logic [6:0] SopkLitOp = 7'h15;
  localparam int CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegStopAtEnd = 1'b0;

  typedef struct packed {
    logic [PcW-1:0] inst_pc;
    enc_class_t     enc_class;
    logic [9:0]     opcode;
    logic [2:0]     size_dwords;
    ext_t           extension;
    logic           literal_flag;
    logic [31:0]    trailing_word;
    logic [31:0]    first_word;
    logic [31:0]    second_word;
    logic           ends_decode;
  } result_t;

  // first dword decode summary
  typedef struct packed {
    enc_class_t cls;
    logic [9:0] op;
    logic [2:0] base;
    ext_t       ext;
    logic       lit;
  } first_dec_t;

endpackage

// ----- hdl/gisd_if.sv -----
interface gisd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        last_word;
  modport source (output valid, code_word, last_word, input ready);
  modport sink (input valid, code_word, last_word, output ready);
endinterface

interface gisd_out_if;
  import gisd_pkg::*;
  logic        valid;
  logic        ready;
  result_t     res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

// ----- hdl/gisd_first_dec.sv -----
module gisd_first_dec
  import gisd_pkg::*;
(
  input  logic [31:0] w,
  output first_dec_t  dec
);
  logic [5:0] v;
  logic [6:0] s;
  logic [8:0] lo9;
  ext_t       vx;
  enc_class_t c;
  logic [9:0] op;
  logic [2:0] base;
  logic       lit;

  always_comb begin
    v = w[30:25];
    s = w[29:23];
    lo9 = w[8:0];
    unique case (lo9)
      9'd233:  vx = X_DPP8;
      9'd234:  vx = X_DPP8FI;
      9'd249:  vx = X_SDWA;
      9'd250:  vx = X_DPP;
      9'd255:  vx = X_LIT;
      default: vx = X_NONE;
    endcase
    c = F_UNK;
    op = '0;
    if (!w[31]) begin
      if (v == 6'h3F) begin
        c = F_VOP1; op = {2'b0, w[16:9]};
      end else if (v == 6'h3E) begin
        c = F_VOPC; op = {2'b0, w[24:17]};
      end else begin
        c = F_VOP2; op = {4'b0, v};
      end
    end else if (!w[30]) begin
      if (s == 7'h7D) begin
        c = F_SOP1; op = {2'b0, w[15:8]};
      end else if (s == 7'h7E) begin
        c = F_SOPC; op = {3'b0, w[22:16]};
      end else if (s == 7'h7F) begin
        c = F_SOPP; op = {3'b0, w[22:16]};
      end else if (s >= 7'h60) begin
        c = F_SOPK; op = {5'b0, w[27:23]};
      end else begin
        c = F_SOP2; op = {3'b0, s};
      end
    end else begin
      unique case (w[31:26])
        6'h32: begin c = F_VINTRP; op = {8'b0, w[17:16]}; end
        6'h33: if (w[31:24] == 8'hCC && !w[23]) begin
          c = F_VOP3P; op = {3'b0, w[22:16]};
        end
        6'h35: begin c = F_VOP3; op = w[25:16]; end
        6'h36: begin c = F_DS; op = {2'b0, w[25:18]}; end
        6'h37: begin c = F_FLAT; op = {3'b0, w[24:18]}; end
        6'h38: begin c = F_MUBUF; op = {2'b0, w[25], w[24:18]}; end
        6'h3A: begin c = F_MTBUF; op = {7'b0, w[18:16]}; end
        6'h3C: begin c = F_MIMG; op = {2'b0, w[0], w[24:18]}; end
        6'h3D: begin c = F_SMEM; op = {2'b0, w[25:18]}; end
        6'h31: if (w[3:0] == 4'h0) begin
          c = F_EXP; op = {4'b0, w[9:4]};
        end
        6'h3E: begin c = F_EXP; op = {4'b0, w[9:4]}; end
        default: ;
      endcase
    end
    unique case (c)
      F_VOP3, F_VOP3P, F_SMEM, F_DS, F_FLAT, F_MUBUF, F_MTBUF, F_EXP: base = 3'd2;
      F_MIMG:  base = 3'd2 + {1'b0, w[2:1]};
      default: base = 3'd1;
    endcase
    if (w[31:26] == 6'h31) base = 3'd2;
    lit = 1'b0;
    dec.ext = X_NONE;
    unique case (c)
      F_SOP2, F_SOPC: lit = (w[7:0] == 8'hFF) || (w[15:8] == 8'hFF);
      F_SOP1: lit = (w[7:0] == 8'hFF);
      F_SOPK: lit = (op[6:0] == SopkLitOp);
      F_VOP2: begin
        dec.ext = vx;
        lit = (vx != X_NONE) || op == 10'h20 || op == 10'h21 || op == 10'h2C ||
              op == 10'h2D || op == 10'h37 || op == 10'h38;
      end
      F_VOP1, F_VOPC: begin
        dec.ext = vx;
        lit = (vx != X_NONE);
      end
      default: ;
    endcase
    if (base != 3'd1) begin
      dec.ext = X_NONE;
      lit = 1'b0;
    end
    dec.cls = c;
    dec.op = op;
    dec.base = base;
    dec.lit = lit;
  end
endmodule

// ----- hdl/gpu_instruction_stream_decoder_unit.sv -----
// channel  dir  payload                                  handshake
// in_      in   code_word[31:0], last_word                valid/ready
// out_     out  result_t (decoded instruction record)     valid/ready
// cfg_     in   apb, reg 0 stop_at_program_end @ 0x0      psel/penable
//
// one request per cycle while the skid entry is empty: each dword is decoded in the cycle it is taken and the
// result, if any, is registered into the output stage the same edge
// an output skid register lets input continue while one result waits unread
// rst_n is synchronous, active low; clears control state and sets
// stop_at_program_end to 1
module gpu_instruction_stream_decoder_unit
  import gisd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  gisd_in_if.sink             in_ch,
  gisd_out_if.source          out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW+1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
`include "gpu_instruction_stream_decoder_unit_defines.svh"

  // config register
  logic stop_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[CfgAddrW+1:2] == RegStopAtEnd) ? {31'b0, stop_r} : 32'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[CfgAddrW+1:2] == RegStopAtEnd) begin
      stop_r <= cfg_pwdata[0];
    end
  end

  // decode state
  logic [2:0]     pos_r, pos_nxt;
  logic [2:0]     base_r, base_nxt;
  logic [31:0]    w0_r, w0_nxt, w1_r, w1_nxt;
  enc_class_t     cls_r, cls_nxt;
  logic [9:0]     op_r, op_nxt;
  ext_t           ext_r, ext_nxt;
  logic           litp_r, litp_nxt;
  logic [PcW-1:0] off_r, off_nxt;
  logic           skip_r, skip_nxt;

  // output skid: main register plus one spare entry
  logic    ov_r, sv_r;
  result_t ores_r, sres_r;
  logic    emit;
  result_t res;
  logic    acc;

  first_dec_t fd;
  gisd_first_dec u_first (.w(in_ch.code_word), .dec(fd));

  assign in_ch.ready = !sv_r;
  assign acc = in_ch.valid && in_ch.ready;

  logic        last;
  logic [31:0] w;
  logic [9:0]  hop;
  logic [1:0]  nsrc;
  logic        v3lit;
  logic        ends;

  // number of vop3/vop3p sources scanned for literal code
  always_comb begin
    nsrc = 2'd2;
    if (cls_r == F_VOP3P) begin
      unique case (op_r)
        10'h00, 10'h09, 10'h0E, 10'h13, 10'h14, 10'h15, 10'h16, 10'h17, 10'h18,
        10'h19, 10'h20, 10'h21, 10'h22: nsrc = 2'd3;
        default: nsrc = 2'd2;
      endcase
    end else if (op_r < 10'h100) nsrc = 2'd2;
    else if (op_r == 10'h101 || (op_r >= 10'h128 && op_r <= 10'h12A)) nsrc = 2'd3;
    else if (op_r < 10'h140) nsrc = 2'd2;
    else if (op_r >= 10'h180 && op_r < 10'h200) nsrc = 2'd1;
    else if (op_r >= 10'h270 && op_r <= 10'h272) nsrc = 2'd2;
    else nsrc = 2'd3;
  end

  always_comb begin
    w = in_ch.code_word;
    last = in_ch.last_word || (off_r == LastOffset);
    pos_nxt = pos_r; base_nxt = base_r; w0_nxt = w0_r; w1_nxt = w1_r;
    cls_nxt = cls_r; op_nxt = op_r; ext_nxt = ext_r; litp_nxt = litp_r;
    off_nxt = off_r; skip_nxt = skip_r;
    emit = 1'b0;
    res = '0;
    res.inst_pc = off_r - {{(PcW-3){1'b0}}, pos_r};
    res.first_word = w0_r;
    res.second_word = w1_r;
    hop = op_r;
    v3lit = 1'b0;
    ends = 1'b0;
    // a completed instruction clears pos and advances the offset; a cut-off one is reset by the window close below
    if (skip_r) begin
      off_nxt = off_r + PcW'(1);
    end else if (litp_r) begin
      emit = 1'b1;
      res.enc_class = cls_r; res.opcode = op_r; res.size_dwords = base_r + 3'd1;
      res.trailing_word = w;
      if (ext_r == X_NONE || ext_r == X_LIT) begin
        res.extension = X_LIT; res.literal_flag = 1'b1;
      end else res.extension = ext_r;
      pos_nxt = '0; litp_nxt = 1'b0; off_nxt = off_r + PcW'(1);
    end else if (pos_r == 3'd0) begin
      res.inst_pc = off_r;
      res.first_word = w;
      res.second_word = '0;
      w0_nxt = w; w1_nxt = '0; cls_nxt = fd.cls; op_nxt = fd.op; base_nxt = fd.base;
      ext_nxt = fd.ext;
      if (fd.base > 3'd1 || fd.lit) begin
        if (last) begin
          emit = 1'b1; res.size_dwords = 3'd1; res.extension = fd.ext;
        end else begin
          litp_nxt = fd.lit; pos_nxt = 3'd1; off_nxt = off_r + PcW'(1);
        end
      end else begin
        ends = fd.cls == F_SOPP && (fd.op[6:0] == SoppCodeEnd || (stop_r &&
               (fd.op[6:0] == SoppEndPgm || fd.op[6:0] == SoppEndA ||
                fd.op[6:0] == SoppEndB)));
        emit = 1'b1;
        res.enc_class = fd.cls; res.opcode = fd.op; res.size_dwords = 3'd1;
        res.extension = fd.ext; res.ends_decode = ends;
        off_nxt = off_r + PcW'(1); skip_nxt = ends;
      end
    end else begin
      if (pos_r == 3'd1) begin
        w1_nxt = w;
        if (cls_r == F_MTBUF) hop = op_r | {6'b0, w[21], 3'b0};
      end
      op_nxt = hop;
      res.second_word = w1_nxt;
      if (pos_r + 3'd1 >= base_r) begin
        if (cls_r == F_VOP3 || cls_r == F_VOP3P) begin
          v3lit = (w1_nxt[8:0] == LitCode) ||
                  (nsrc != 2'd1 && w1_nxt[17:9] == LitCode) ||
                  (nsrc == 2'd3 && w1_nxt[26:18] == LitCode);
        end
        if (v3lit && !last) begin
          litp_nxt = 1'b1; pos_nxt = pos_r + 3'd1; off_nxt = off_r + PcW'(1);
        end else begin
          emit = 1'b1; res.size_dwords = base_r; res.extension = ext_r;
          if (!v3lit) begin
            res.enc_class = cls_r; res.opcode = hop;
          end
          pos_nxt = '0; off_nxt = off_r + PcW'(1);
        end
      end else if (last) begin
        emit = 1'b1; res.size_dwords = pos_r + 3'd1;
      end else begin
        pos_nxt = pos_r + 3'd1; off_nxt = off_r + PcW'(1);
      end
    end
    // window close resets position, base, literal-pending, offset and skip state
    if (last) begin
      pos_nxt = '0; base_nxt = '0; litp_nxt = 1'b0; off_nxt = '0; skip_nxt = 1'b0;
    end
    if (!acc) emit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; base_r <= '0; litp_r <= 1'b0; off_r <= '0; skip_r <= 1'b0;
      w0_r <= '0; w1_r <= '0; cls_r <= F_UNK; op_r <= '0; ext_r <= X_NONE;
    end else if (acc) begin
      pos_r <= pos_nxt; base_r <= base_nxt; litp_r <= litp_nxt; off_r <= off_nxt;
      skip_r <= skip_nxt; w0_r <= w0_nxt; w1_r <= w1_nxt; cls_r <= cls_nxt;
      op_r <= op_nxt; ext_r <= ext_nxt;
    end
  end

  // output stage with skid
  logic pop;
  assign pop = ov_r && out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.res = ores_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (!ov_r || pop) begin
        ov_r <= sv_r || emit;
        sv_r <= sv_r && emit;
      end else if (emit) begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || pop) begin
      ores_r <= sv_r ? sres_r : res;
      if (sv_r && emit) sres_r <= res;
    end else if (emit) begin
      sres_r <= res;
    end
  end

  `GISD_ASSERT_IMPL(a_skid_needs_main, clk, rst_n, sv_r, ov_r)
  `GISD_ASSERT_IMPL(a_no_take_when_full, clk, rst_n, sv_r, !in_ch.ready)
  `GISD_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, ov_r)
  `GISD_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_r <= 3'd5)
endmodule
